[design/ssd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Types and constants shared by the segment distance pipeline and its checker.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int CW      = 32;          // coordinate, signed Q16.16
    localparam int DW      = CW + 1;      // coordinate difference
    localparam int PW      = 2 * DW;      // product of two differences
    localparam int SW      = PW + 1;      // sum of two products
    localparam int DIST_W  = 33;          // distance, unsigned Q17.16

    // pipelined rounding divider
    localparam int DIV_AW  = SW - 1;      // dividend factor magnitude
    localparam int DIV_BW  = DW;          // multiplier magnitude
    localparam int DIV_QW  = 33;          // quotient bits
    localparam int DIV_PPW = 22;          // partial product slice of the dividend factor
    localparam int DIV_NPP = (DIV_AW + DIV_PPW - 1) / DIV_PPW;
    localparam int DIV_NW  = DIV_AW + DIV_BW + 1;
    localparam int DIV_LAT = 2 + DIV_QW;

    // pipelined square root
    localparam int SQ_RW   = 35;          // root bits
    localparam int SQ_MW   = 2 * SQ_RW;   // radicand / remainder bits

    // how a nearest point is formed
    localparam logic [1:0] NEAR_V   = 2'd0;   // segment start
    localparam logic [1:0] NEAR_W   = 2'd1;   // segment end
    localparam logic [1:0] NEAR_DIV = 2'd2;   // start plus divided offset

    localparam logic [1:0] ST_DISJOINT = 2'd0;
    localparam logic [1:0] ST_CROSS    = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0]    distance;
        logic signed [CW-1:0] near_a_x;
        logic signed [CW-1:0] near_a_y;
        logic signed [CW-1:0] near_b_x;
        logic signed [CW-1:0] near_b_y;
        logic [1:0]           status;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_pt;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
    } t_vec;

    typedef struct packed {
        t_in        pts;
        logic       hit;
        logic       degen;
        logic [3:0][1:0] clamp;
        logic [7:0] neg;
    } t_side;

endpackage

[design/ssd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined a*b/d, rounded to nearest with ties away from zero, on magnitudes.
// Two stages build 2*a*b + d, then one quotient bit per stage against 2*d.
// ----------------------------------------------------------------------------
module ssd_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ssd_pkg::DIV_AW-1:0]   i_a,
    input  logic [ssd_pkg::DIV_BW-1:0]   i_b,
    input  logic [ssd_pkg::DIV_AW-1:0]   i_d,
    output logic [ssd_pkg::DIV_QW-1:0]   o_q
);
    import ssd_pkg::*;

    localparam int PPW = DIV_PPW + DIV_BW;

    logic [PPW-1:0]     r_pp  [DIV_NPP];
    logic [DIV_AW-1:0]  r_d0;
    logic [DIV_NW-1:0]  n_num;
    logic [DIV_NW-1:0]  r_rem [DIV_QW+1];
    logic [DIV_AW:0]    r_den [DIV_QW+1];
    logic [DIV_QW-1:0]  r_q   [DIV_QW+1];
    logic [DIV_AW-1:0]  w_a;

    assign w_a = i_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_NPP; i++) begin
                r_pp[i] <= PPW'(w_a[i*DIV_PPW +: DIV_PPW]) * PPW'(i_b);
            end
            r_d0 <= i_d;
        end
    end

    always_comb begin
        n_num = '0;
        for (int i = 0; i < DIV_NPP; i++) begin
            n_num = n_num + (DIV_NW'(r_pp[i]) << (i * DIV_PPW));
        end
    end

    // rounding: floor((2n + d) / 2d)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (n_num << 1) + DIV_NW'(r_d0);
            r_den[0] <= {r_d0, 1'b0};
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 0; s < DIV_QW; s++) begin : g_step
        localparam int BIT = DIV_QW - 1 - s;
        logic [DIV_NW-1:0] w_trial;
        logic              w_ge;

        assign w_trial = DIV_NW'(r_den[s]) << BIT;
        assign w_ge    = (r_rem[s] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? (r_rem[s] - w_trial) : r_rem[s];
                r_den[s+1] <= r_den[s];
                r_q[s+1]   <= r_q[s] | (w_ge ? (DIV_QW'(1) << BIT) : '0);
            end
        end
    end

    assign o_q = r_q[DIV_QW];

endmodule

[design/segment_segment_distance_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_distance_top
// Minimum distance and nearest points between two 2-D segments, Q16.16.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock and passes each result through 80 register
// stages. The stage count is set by the 33-step rounding dividers, one per
// nearest-point coordinate (35 stages), and the 35-step square root; front
// end, projection and select add nine stages and the output register one
// more. A stall while a result is valid on the output freezes the whole
// pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module segment_segment_distance_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ssd_pkg::t_in   i_data,
    output logic           o_stall,
    output logic           o_valid,
    output ssd_pkg::t_out  o_data,
    input  logic           i_stall
);
    import ssd_pkg::*;

    localparam int NPROD    = 12;
    localparam int NSUB     = 5;     // cross terms and denominator subtract
    localparam int IX_DENOM = 4;
    localparam int IX_NUMER = 5;
    localparam int IX_LEN_U = 6;
    localparam int IX_LEN_V = 7;
    localparam int IX_DP    = 8;
    localparam int NPRJ     = 4;
    localparam int NLANE    = 2 * NPRJ;
    localparam logic [1:0] PT_AS = 2'd0;
    localparam logic [1:0] PT_AE = 2'd1;
    localparam logic [1:0] PT_BS = 2'd2;
    localparam logic [1:0] PT_BE = 2'd3;

    function automatic t_pt pnt(t_in p, logic [1:0] j);
        t_pt r;
        case (j)
            PT_AS:   begin r.x = p.a_start_x; r.y = p.a_start_y; end
            PT_AE:   begin r.x = p.a_end_x;   r.y = p.a_end_y;   end
            PT_BS:   begin r.x = p.b_start_x; r.y = p.b_start_y; end
            default: begin r.x = p.b_end_x;   r.y = p.b_end_y;   end
        endcase
        return r;
    endfunction

    function automatic t_vec dif(t_pt a, t_pt b);
        t_vec r;
        r.x = DW'(a.x) - DW'(b.x);
        r.y = DW'(a.y) - DW'(b.y);
        return r;
    endfunction

    function automatic logic same_side(logic signed [SW-1:0] a, logic signed [SW-1:0] b);
        return (a != 0) && (b != 0) && (a[SW-1] == b[SW-1]);
    endfunction

    function automatic logic [DIV_AW-1:0] mag(logic signed [SW-1:0] x);
        logic [SW-1:0] t;
        t = x[SW-1] ? -x : x;
        return t[DIV_AW-1:0];
    endfunction

    function automatic logic [DIV_BW-1:0] absv(logic signed [DW-1:0] x);
        return x[DW-1] ? -x : x;
    endfunction

    function automatic logic signed [CW-1:0] near_coord(logic [1:0] cl,
                                                       logic signed [CW-1:0] base,
                                                       logic signed [CW-1:0] far,
                                                       logic neg,
                                                       logic [DIV_QW-1:0] q);
        logic [CW+1:0] off;
        logic [CW+1:0] sum;
        off = neg ? -((CW+2)'(q)) : (CW+2)'(q);
        sum = (CW+2)'(base) + off;
        case (cl)
            NEAR_V:   return base;
            NEAR_W:   return far;
            default:  return sum[CW-1:0];
        endcase
    endfunction

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // ---------------- stage 1: differences
    logic r_s1_vld;
    t_in  r_s1_pts;
    t_vec r_s1_u, r_s1_v;
    t_vec r_s1_e [8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pts  <= i_data;
            r_s1_u    <= dif(pnt(i_data, PT_AE), pnt(i_data, PT_AS));
            r_s1_v    <= dif(pnt(i_data, PT_BE), pnt(i_data, PT_BS));
            r_s1_e[0] <= dif(pnt(i_data, PT_BS), pnt(i_data, PT_AE));
            r_s1_e[1] <= dif(pnt(i_data, PT_BE), pnt(i_data, PT_AE));
            r_s1_e[2] <= dif(pnt(i_data, PT_AS), pnt(i_data, PT_BE));
            r_s1_e[3] <= dif(pnt(i_data, PT_AE), pnt(i_data, PT_BE));
            r_s1_e[4] <= dif(pnt(i_data, PT_AS), pnt(i_data, PT_BS));
            r_s1_e[5] <= dif(pnt(i_data, PT_AE), pnt(i_data, PT_BS));
            r_s1_e[6] <= dif(pnt(i_data, PT_BS), pnt(i_data, PT_AS));
            r_s1_e[7] <= dif(pnt(i_data, PT_BE), pnt(i_data, PT_AS));
        end
    end

    // ---------------- stage 2: products, pa*pb (+/-) pc*pd
    logic signed [DW-1:0] n_ma [NPROD];
    logic signed [DW-1:0] n_mb [NPROD];
    logic signed [DW-1:0] n_mc [NPROD];
    logic signed [DW-1:0] n_md [NPROD];
    logic                 r_s2_vld;
    t_in                  r_s2_pts;
    t_vec                 r_s2_u, r_s2_v;
    logic signed [PW-1:0] r_s2_pa [NPROD];
    logic signed [PW-1:0] r_s2_pb [NPROD];

    always_comb begin
        // cross products of the crossing test
        n_ma[0] = r_s1_u.x; n_mb[0] = r_s1_e[0].y; n_mc[0] = r_s1_u.y; n_md[0] = r_s1_e[0].x;
        n_ma[1] = r_s1_u.x; n_mb[1] = r_s1_e[1].y; n_mc[1] = r_s1_u.y; n_md[1] = r_s1_e[1].x;
        n_ma[2] = r_s1_v.x; n_mb[2] = r_s1_e[2].y; n_mc[2] = r_s1_v.y; n_md[2] = r_s1_e[2].x;
        n_ma[3] = r_s1_v.x; n_mb[3] = r_s1_e[3].y; n_mc[3] = r_s1_v.y; n_md[3] = r_s1_e[3].x;
        // line intersection denominator and numerator
        n_ma[4] = r_s1_u.y; n_mb[4] = r_s1_v.x;    n_mc[4] = r_s1_u.x; n_md[4] = r_s1_v.y;
        n_ma[5] = r_s1_v.x; n_mb[5] = r_s1_e[6].y; n_mc[5] = r_s1_v.y; n_md[5] = r_s1_e[4].x;
        // squared lengths
        n_ma[6] = r_s1_u.x; n_mb[6] = r_s1_u.x;    n_mc[6] = r_s1_u.y; n_md[6] = r_s1_u.y;
        n_ma[7] = r_s1_v.x; n_mb[7] = r_s1_v.x;    n_mc[7] = r_s1_v.y; n_md[7] = r_s1_v.y;
        // projection dot products
        n_ma[8]  = r_s1_e[4].x; n_mb[8]  = r_s1_v.x; n_mc[8]  = r_s1_e[4].y; n_md[8]  = r_s1_v.y;
        n_ma[9]  = r_s1_e[5].x; n_mb[9]  = r_s1_v.x; n_mc[9]  = r_s1_e[5].y; n_md[9]  = r_s1_v.y;
        n_ma[10] = r_s1_e[6].x; n_mb[10] = r_s1_u.x; n_mc[10] = r_s1_e[6].y; n_md[10] = r_s1_u.y;
        n_ma[11] = r_s1_e[7].x; n_mb[11] = r_s1_u.x; n_mc[11] = r_s1_e[7].y; n_md[11] = r_s1_u.y;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_pts <= r_s1_pts;
            r_s2_u   <= r_s1_u;
            r_s2_v   <= r_s1_v;
            for (int k = 0; k < NPROD; k++) begin
                r_s2_pa[k] <= PW'(n_ma[k]) * PW'(n_mb[k]);
                r_s2_pb[k] <= PW'(n_mc[k]) * PW'(n_md[k]);
            end
        end
    end

    // ---------------- stage 3: sums
    logic                 r_s3_vld;
    t_in                  r_s3_pts;
    t_vec                 r_s3_u, r_s3_v;
    logic signed [SW-1:0] r_s3_s [NPROD];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_pts <= r_s2_pts;
            r_s3_u   <= r_s2_u;
            r_s3_v   <= r_s2_v;
            for (int k = 0; k < NPROD; k++) begin
                r_s3_s[k] <= (k < NSUB) ? (SW'(r_s2_pa[k]) - SW'(r_s2_pb[k]))
                                        : (SW'(r_s2_pa[k]) + SW'(r_s2_pb[k]));
            end
        end
    end

    // ---------------- stage 4: crossing test, clamps, divider operands
    logic              r_s4_vld;
    logic [DIV_AW-1:0] n_s4_a [NLANE];
    logic [DIV_BW-1:0] n_s4_b [NLANE];
    logic [DIV_AW-1:0] n_s4_d [NLANE];
    t_side             n_s4_side;
    logic [DIV_AW-1:0] r_s4_a [NLANE];
    logic [DIV_BW-1:0] r_s4_b [NLANE];
    logic [DIV_AW-1:0] r_s4_d [NLANE];
    t_side             r_s4_side;

    always_comb begin
        logic signed [SW-1:0] len;
        logic signed [SW-1:0] dp;
        logic signed [DW-1:0] cmp;
        logic [1:0]           cl;
        logic                 isect;
        n_s4_side.pts   = r_s3_pts;
        n_s4_side.hit   = !same_side(r_s3_s[0], r_s3_s[1]) && !same_side(r_s3_s[2], r_s3_s[3]);
        n_s4_side.degen = (r_s3_s[IX_LEN_U] == 0) || (r_s3_s[IX_LEN_V] == 0)
                       || (r_s3_s[IX_DENOM] == 0);
        isect = n_s4_side.hit && !n_s4_side.degen;
        for (int j = 0; j < NPRJ; j++) begin
            len = (j < 2) ? r_s3_s[IX_LEN_V] : r_s3_s[IX_LEN_U];
            dp  = r_s3_s[IX_DP + j];
            if (len == 0 || dp <= 0) begin
                cl = NEAR_V;
            end else if (dp >= len) begin
                cl = NEAR_W;
            end else begin
                cl = NEAR_DIV;
            end
            // lane pair 0 carries the line intersection when the segments cross
            if (j == 0 && isect) begin
                cl = NEAR_DIV;
            end
            n_s4_side.clamp[j] = cl;
            for (int c = 0; c < 2; c++) begin
                if (j < 2) begin
                    cmp = (c == 1) ? r_s3_v.y : r_s3_v.x;
                end else begin
                    cmp = (c == 1) ? r_s3_u.y : r_s3_u.x;
                end
                if (j == 0 && isect) begin
                    cmp = (c == 1) ? r_s3_u.y : r_s3_u.x;
                    n_s4_a[2*j+c]      = mag(r_s3_s[IX_NUMER]);
                    n_s4_b[2*j+c]      = absv(cmp);
                    n_s4_d[2*j+c]      = mag(r_s3_s[IX_DENOM]);
                    n_s4_side.neg[2*j+c] = r_s3_s[IX_NUMER][SW-1] ^ cmp[DW-1]
                                         ^ r_s3_s[IX_DENOM][SW-1];
                end else begin
                    n_s4_a[2*j+c]      = (cl == NEAR_DIV) ? mag(dp) : '0;
                    n_s4_b[2*j+c]      = absv(cmp);
                    n_s4_d[2*j+c]      = mag(len);
                    n_s4_side.neg[2*j+c] = cmp[DW-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_a    <= n_s4_a;
            r_s4_b    <= n_s4_b;
            r_s4_d    <= n_s4_d;
            r_s4_side <= n_s4_side;
        end
    end

    // ---------------- dividers
    logic [DIV_QW-1:0] w_q [NLANE];
    t_side             r_dside [DIV_LAT];
    logic              r_dvld  [DIV_LAT];

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        ssd_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_s4_a[g]),
            .i_b   (r_s4_b[g]),
            .i_d   (r_s4_d[g]),
            .o_q   (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dside[0] <= r_s4_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dside[i] <= r_dside[i-1];
            end
        end
    end

    // ---------------- stage E: nearest points
    logic  r_e_vld;
    t_side r_e_side;
    t_pt   n_e_near [NPRJ];
    t_pt   r_e_near [NPRJ];

    always_comb begin
        t_pt   base;
        t_pt   far;
        t_side ds;
        ds = r_dside[DIV_LAT-1];
        for (int j = 0; j < NPRJ; j++) begin
            if (j < 2) begin
                base = (ds.hit && j == 0) ? pnt(ds.pts, PT_AS) : pnt(ds.pts, PT_BS);
                far  = pnt(ds.pts, PT_BE);
            end else begin
                base = pnt(ds.pts, PT_AS);
                far  = pnt(ds.pts, PT_AE);
            end
            n_e_near[j].x = near_coord(ds.clamp[j], base.x, far.x, ds.neg[2*j],   w_q[2*j]);
            n_e_near[j].y = near_coord(ds.clamp[j], base.y, far.y, ds.neg[2*j+1], w_q[2*j+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_side <= r_dside[DIV_LAT-1];
            r_e_near <= n_e_near;
        end
    end

    // ---------------- stage F: endpoint minus nearest point
    logic  r_f_vld;
    t_side r_f_side;
    t_pt   r_f_near [NPRJ];
    t_vec  r_f_dif  [NPRJ];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_side <= r_e_side;
            r_f_near <= r_e_near;
            for (int j = 0; j < NPRJ; j++) begin
                r_f_dif[j] <= dif(pnt(r_e_side.pts, 2'(j)), r_e_near[j]);
            end
        end
    end

    // ---------------- stage G: squares
    logic           r_g_vld;
    t_side          r_g_side;
    t_pt            r_g_near [NPRJ];
    logic [PW-2:0]  r_g_sx   [NPRJ];
    logic [PW-2:0]  r_g_sy   [NPRJ];
    logic [PW-1:0]  n_g_sx   [NPRJ];
    logic [PW-1:0]  n_g_sy   [NPRJ];

    always_comb begin
        for (int j = 0; j < NPRJ; j++) begin
            n_g_sx[j] = PW'(r_f_dif[j].x) * PW'(r_f_dif[j].x);
            n_g_sy[j] = PW'(r_f_dif[j].y) * PW'(r_f_dif[j].y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_side <= r_f_side;
            r_g_near <= r_f_near;
            for (int j = 0; j < NPRJ; j++) begin
                r_g_sx[j] <= n_g_sx[j][PW-2:0];
                r_g_sy[j] <= n_g_sy[j][PW-2:0];
            end
        end
    end

    // ---------------- stage H: squared distances
    logic          r_h_vld;
    t_side         r_h_side;
    t_pt           r_h_near [NPRJ];
    logic [PW-1:0] r_h_d    [NPRJ];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_side <= r_g_side;
            r_h_near <= r_g_near;
            for (int j = 0; j < NPRJ; j++) begin
                r_h_d[j] <= PW'(r_g_sx[j]) + PW'(r_g_sy[j]);
            end
        end
    end

    // ---------------- stage I: pick the candidate, feed the square root
    logic               r_sv    [SQ_RW+1];
    logic [SQ_MW-1:0]   r_srem  [SQ_RW+1];
    logic [SQ_RW-1:0]   r_sroot [SQ_RW+1];
    t_pt                r_sqa   [SQ_RW+1];
    t_pt                r_sqb   [SQ_RW+1];
    logic [1:0]         r_sst   [SQ_RW+1];
    logic [PW-1:0]      n_i_s;
    t_pt                n_i_qa, n_i_qb;
    logic [1:0]         n_i_st;

    always_comb begin
        t_in p;
        p = r_h_side.pts;
        if (r_h_side.hit) begin
            n_i_s  = '0;
            n_i_st = r_h_side.degen ? ST_NONE : ST_CROSS;
            n_i_qa = r_h_side.degen ? pnt(p, PT_AS) : r_h_near[0];
            n_i_qb = n_i_qa;
        end else begin
            n_i_st = ST_DISJOINT;
            // first candidate not beaten by any later one wins
            if (r_h_d[0] <= r_h_d[1] && r_h_d[0] <= r_h_d[2] && r_h_d[0] <= r_h_d[3]) begin
                n_i_s = r_h_d[0]; n_i_qa = pnt(p, PT_AS); n_i_qb = r_h_near[0];
            end else if (r_h_d[1] <= r_h_d[2] && r_h_d[1] <= r_h_d[3]) begin
                n_i_s = r_h_d[1]; n_i_qa = pnt(p, PT_AE); n_i_qb = r_h_near[1];
            end else if (r_h_d[2] <= r_h_d[3]) begin
                n_i_s = r_h_d[2]; n_i_qa = r_h_near[2];   n_i_qb = pnt(p, PT_BS);
            end else begin
                n_i_s = r_h_d[3]; n_i_qa = r_h_near[3];   n_i_qb = pnt(p, PT_BE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_srem[0]  <= SQ_MW'(n_i_s);
            r_sroot[0] <= '0;
            r_sqa[0]   <= n_i_qa;
            r_sqb[0]   <= n_i_qb;
            r_sst[0]   <= n_i_st;
        end
    end

    // ---------------- square root, one root bit per stage
    for (genvar s = 0; s < SQ_RW; s++) begin : g_sqrt
        localparam int BIT = SQ_RW - 1 - s;
        logic [SQ_MW:0] w_t;
        logic           w_ge;

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign w_t  = ((SQ_MW+1)'(r_sroot[s]) << (BIT + 1)) | ((SQ_MW+1)'(1) << (2 * BIT));
        assign w_ge = ((SQ_MW+1)'(r_srem[s]) >= w_t);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_srem[s+1]  <= w_ge ? (r_srem[s] - w_t[SQ_MW-1:0]) : r_srem[s];
                r_sroot[s+1] <= r_sroot[s] | (w_ge ? (SQ_RW'(1) << BIT) : '0);
                r_sqa[s+1]   <= r_sqa[s];
                r_sqb[s+1]   <= r_sqb[s];
                r_sst[s+1]   <= r_sst[s];
            end
        end
    end

    // ---------------- output register: round and saturate
    logic [SQ_RW:0]   n_rnd;
    logic [DIST_W-1:0] n_dist;
    t_out             r_out;
    logic             r_ovld;

    always_comb begin
        n_rnd = (SQ_RW+1)'(r_sroot[SQ_RW]);
        if (r_srem[SQ_RW] > SQ_MW'(r_sroot[SQ_RW])) begin
            n_rnd = n_rnd + 1'b1;
        end
        n_dist = (n_rnd[SQ_RW:DIST_W] != '0) ? '1 : n_rnd[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.distance <= n_dist;
            r_out.near_a_x <= r_sqa[SQ_RW].x;
            r_out.near_a_y <= r_sqa[SQ_RW].y;
            r_out.near_b_x <= r_sqb[SQ_RW].x;
            r_out.near_b_y <= r_sqb[SQ_RW].y;
            r_out.status   <= r_sst[SQ_RW];
        end
    end

    // ---------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dvld[i] <= 1'b0;
            end
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            for (int i = 0; i <= SQ_RW; i++) begin
                r_sv[i] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_dvld[0] <= r_s4_vld;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dvld[i] <= r_dvld[i-1];
            end
            r_e_vld <= r_dvld[DIV_LAT-1];
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_sv[0] <= r_h_vld;
            for (int i = 1; i <= SQ_RW; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
            r_ovld <= r_sv[SQ_RW];
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule

[design/ssd_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_chk
// Port-level checks of the segment distance block, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input ssd_pkg::t_in  i_data,
    input logic          o_stall,
    input logic          o_valid,
    input ssd_pkg::t_out o_data,
    input logic          i_stall
);
    import ssd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output transaction changed while stalled");

    // the input side only backs up when a finished result is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output register");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_DISJOINT |-> o_data.distance == '0)
        else $error("nonzero distance on crossing or degenerate pair");

    a_same_pt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_CROSS || o_data.status == ST_NONE)
        |-> o_data.near_a_x == o_data.near_b_x && o_data.near_a_y == o_data.near_b_y)
        else $error("crossing result with two different points");

endmodule

bind segment_segment_distance_top ssd_chk u_ssd_chk (.*);

[dv/segment_segment_distance_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_distance_top_test
// Self-checking bench for the segment distance pipeline: directed corner
// pairs, then random pairs (collinear, degenerate, parallel offset, wild),
// with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module segment_segment_distance_top_test;
    import ssd_pkg::*;

    localparam int LATENCY   = 80;
    localparam int WDOG_MAX  = 20000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    t_in   i_data = '0;
    logic  o_stall;
    logic  o_valid;
    t_out  o_data;
    logic  i_stall = 1'b0;

    t_out  expected_q[$];
    int    n_errors = 0;
    int    idle_cycles = 0;
    bit    src_idle_en = 1'b1;
    bit    sink_idle_en = 1'b1;
    int    hold_off = 0;
    int    hold_req = 0;
    int    hold_ack = 0;

    segment_segment_distance_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------- distance predictor ----------------
    function automatic int sgn128(logic signed [127:0] v);
        if (v < 0) return -1;
        return (v != 0) ? 1 : 0;
    endfunction

    // n/d rounded to nearest, ties away from zero
    function automatic logic signed [63:0] div_near(logic signed [127:0] n,
                                                    logic signed [127:0] d);
        logic [127:0] an, ad, q;
        logic signed [63:0] v;
        if (d == 0) return 0;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = ((an << 1) + ad) / (ad << 1);
        v = {17'd0, q[46:0]};
        return ((n < 0) != (d < 0)) ? -v : v;
    endfunction

    function automatic logic signed [127:0] cr(logic signed [63:0] ax, logic signed [63:0] ay,
                                               logic signed [63:0] bx, logic signed [63:0] by);
        logic signed [127:0] r;
        r = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
        return r;
    endfunction

    function automatic logic signed [127:0] dt(logic signed [63:0] ax, logic signed [63:0] ay,
                                               logic signed [63:0] bx, logic signed [63:0] by);
        logic signed [127:0] r;
        r = 128'(ax) * 128'(bx) + 128'(ay) * 128'(by);
        return r;
    endfunction

    function automatic logic signed [127:0] proj_point(
            logic signed [63:0] vx, logic signed [63:0] vy,
            logic signed [63:0] wx, logic signed [63:0] wy,
            logic signed [63:0] px, logic signed [63:0] py,
            output logic signed [63:0] nx, output logic signed [63:0] ny);
        logic signed [63:0] dx, dy;
        logic signed [127:0] len2, dp;
        dx = wx - vx;
        dy = wy - vy;
        len2 = dt(dx, dy, dx, dy);
        dp = dt(px - vx, py - vy, dx, dy);
        if (len2 == 0 || dp <= 0) begin
            nx = vx; ny = vy;
        end else if (dp >= len2) begin
            nx = wx; ny = wy;
        end else begin
            nx = vx + div_near(dp * 128'(dx), len2);
            ny = vy + div_near(dp * 128'(dy), len2);
        end
        return dt(px - nx, py - ny, px - nx, py - ny);
    endfunction

    function automatic logic [32:0] root_near(logic [127:0] s);
        logic [63:0] r, c, b;
        r = 0;
        b = 64'd1 << 34;
        while (b != 0) begin
            c = r + b;
            if (128'(c) * 128'(c) <= s) r = c;
            b = b >> 1;
        end
        if (s - 128'(r) * 128'(r) > 128'(r)) r++;
        return (r > 64'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : r[32:0];
    endfunction

    function automatic bit same_sign(logic signed [127:0] a, logic signed [127:0] b);
        return sgn128(a) != 0 && sgn128(a) == sgn128(b);
    endfunction

    function automatic t_out predict_distance(t_in s);
        logic signed [63:0] x1, y1, x2, y2, x3, y3, x4, y4, ux, uy, vx, vy;
        logic signed [63:0] ax, ay, bx, by, nax, nay, nbx, nby, ncx, ncy, ndx, ndy;
        logic signed [127:0] d1, d2, d3, d4, best, den, num;
        bit hit;
        t_out r;
        x1 = s.a_start_x; y1 = s.a_start_y; x2 = s.a_end_x; y2 = s.a_end_y;
        x3 = s.b_start_x; y3 = s.b_start_y; x4 = s.b_end_x; y4 = s.b_end_y;
        ux = x2 - x1; uy = y2 - y1; vx = x4 - x3; vy = y4 - y3;
        r = '0;
        hit = !same_sign(cr(ux, uy, x3 - x2, y3 - y2), cr(ux, uy, x4 - x2, y4 - y2))
           && !same_sign(cr(vx, vy, x1 - x4, y1 - y4), cr(vx, vy, x2 - x4, y2 - y4));
        if (hit) begin
            den = 128'(uy) * 128'(vx) - 128'(ux) * 128'(vy);
            if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0) || den == 0) begin
                ax = x1; ay = y1;
                r.status = ST_NONE;
            end else begin
                num = 128'(vx) * 128'(y3 - y1) + 128'(vy) * 128'(x1 - x3);
                ax = x1 + div_near(num * 128'(ux), den);
                ay = y1 + div_near(num * 128'(uy), den);
                r.status = ST_CROSS;
            end
            bx = ax; by = ay;
        end else begin
            d1 = proj_point(x3, y3, x4, y4, x1, y1, nax, nay);
            d2 = proj_point(x3, y3, x4, y4, x2, y2, nbx, nby);
            d3 = proj_point(x1, y1, x2, y2, x3, y3, ncx, ncy);
            d4 = proj_point(x1, y1, x2, y2, x4, y4, ndx, ndy);
            if (d1 <= d2 && d1 <= d3 && d1 <= d4) begin
                ax = x1; ay = y1; bx = nax; by = nay; best = d1;
            end else if (d2 <= d3 && d2 <= d4) begin
                ax = x2; ay = y2; bx = nbx; by = nby; best = d2;
            end else if (d3 <= d4) begin
                ax = ncx; ay = ncy; bx = x3; by = y3; best = d3;
            end else begin
                ax = ndx; ay = ndy; bx = x4; by = y4; best = d4;
            end
            r.distance = root_near(best);
            r.status = ST_DISJOINT;
        end
        r.near_a_x = ax[31:0]; r.near_a_y = ay[31:0];
        r.near_b_x = bx[31:0]; r.near_b_y = by[31:0];
        return r;
    endfunction

    // ---------------- sender ----------------
    // valid stays up after a transaction; stop_sending drops it
    task automatic send_pair(t_in s);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.insert(expected_q.size(), predict_distance(s));
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 2 * 327680)) - 327680);
        endcase
    endfunction

    function automatic t_in rand_pair();
        t_in s;
        logic signed [31:0] ox, oy, dx, dy, k;
        s = {pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        case ($urandom_range(0, 9))
            0: begin // collinear, on one line through A
                dx = $signed($urandom_range(0, 4096)) - 2048;
                dy = $signed($urandom_range(0, 4096)) - 2048;
                ox = s.a_start_x >>> 4; oy = s.a_start_y >>> 4;
                s.a_start_x = ox; s.a_start_y = oy;
                k = $urandom_range(0, 40); s.a_end_x = ox + k * dx; s.a_end_y = oy + k * dy;
                k = $signed($urandom_range(0, 80)) - 40;
                s.b_start_x = ox + k * dx; s.b_start_y = oy + k * dy;
                k = $signed($urandom_range(0, 80)) - 40;
                s.b_end_x = ox + k * dx; s.b_end_y = oy + k * dy;
            end
            1: begin // zero-length segment
                if ($urandom_range(0, 1)) begin
                    s.a_end_x = s.a_start_x; s.a_end_y = s.a_start_y;
                end else begin
                    s.b_end_x = s.b_start_x; s.b_end_y = s.b_start_y;
                end
            end
            2: begin // parallel offset
                s.b_start_x = s.a_start_x + 65536; s.b_start_y = s.a_start_y;
                s.b_end_x = s.a_end_x + 65536; s.b_end_y = s.a_end_y;
            end
            default: ;
        endcase
        return s;
    endfunction

    // ---------------- receiver and checker ----------------
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            // long hold-off, counted down in hold_off
            i_stall <= 1'b1;
            hold_off <= 299;
            hold_ack <= hold_req;
        end else if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
            i_stall <= 1'b1;
            hold_off <= $urandom_range(0, 6);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("%t unexpected result: actual %h", $time, o_data);
                n_errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_data.distance !== exp_r.distance || o_data.near_a_x !== exp_r.near_a_x
                        || o_data.near_a_y !== exp_r.near_a_y
                        || o_data.near_b_x !== exp_r.near_b_x
                        || o_data.near_b_y !== exp_r.near_b_y
                        || o_data.status !== exp_r.status) begin
                    $display("%t mismatch: expected %h actual %h", $time, exp_r, o_data);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("segment_segment_distance_top_test failed");
            $finish;
        end
    end

    // ---------------- tests ----------------
    function automatic t_in mk(int x1, int y1, int x2, int y2, int x3, int y3, int x4, int y4);
        t_in s;
        s = {32'(x1), 32'(y1), 32'(x2), 32'(y2), 32'(x3), 32'(y3), 32'(x4), 32'(y4)};
        return s;
    endfunction

    task automatic test_directed();
        int one;
        one = 65536;
        send_pair(mk(0, 0, 2*one, 2*one, 0, 2*one, 2*one, 0));          // crossing
        send_pair(mk(0, 0, one, 0, one, 0, 2*one, one));                // touching at end
        send_pair(mk(0, 0, one, 0, 0, one, one, one));                  // parallel apart
        send_pair(mk(0, 0, 2*one, 0, one, 0, 3*one, 0));                // collinear overlap
        send_pair(mk(0, 0, one, 0, 3*one, 0, 4*one, 0));                // collinear apart
        send_pair(mk(one, one, one, one, 0, 0, 2*one, 2*one));          // point on segment
        send_pair(mk(one, one, one, one, 5*one, 3*one, 5*one, 3*one));  // two points
        send_pair(mk(0, 0, 0, 2*one, one, one, 3*one, 5*one));          // projection
        send_pair(mk(0, 0, 3, 7, 100, -5, 200, 9));                     // rounding
        send_pair(mk(0, 0, one, 0, 0, one, one, 2*one));                // ties
        send_pair(mk(int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000),
                     int'(32'h8000_0000), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF));                    // max distance
        send_pair(mk(int'(32'h8000_0000), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000),
                     32'h7FFF_FFFF, 32'h7FFF_FFFF));                    // extreme crossing
        send_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        send_pair(mk(32'h7FFF_FFFF, 0, int'(32'h8000_0000), 1, 0, 32'h7FFF_FFFF,
                     5, int'(32'h8000_0000)));
    endtask

    task automatic test_random(int n);
        repeat (n) send_pair(rand_pair());
    endtask

    // output held off long enough to fill the pipe and stall the input
    task automatic test_backpressure();
        hold_req++;
        repeat (120) send_pair(rand_pair());
    endtask

    task automatic test_drain_pause();
        stop_sending();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (20) send_pair(rand_pair());
    endtask

    task automatic test_streaming();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (150) send_pair(rand_pair());
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(450);
        test_backpressure();
        test_drain_pause();
        test_random(350);
        test_streaming();
        stop_sending();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("segment_segment_distance_top_test passed");
        else
            $display("segment_segment_distance_top_test failed");
        $finish;
    end

endmodule
